@@ rtl/core/bb3_pkg.sv @@
`default_nettype none

package bb3_pkg;

  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int SUM_W  = 12;
  localparam int FW_W   = 11;
  localparam int FH_W   = 16;
  localparam int CFG_W  = 16;
  localparam int PROD_W = 26;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(1024);
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(768);
  localparam int              MIN_SIZE         = 2;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // mean of 6 and of 9 by reciprocal multiply, exact over the sum range
  localparam int unsigned RECIP6 = 2731;
  localparam int          SHIFT6 = 14;
  localparam int unsigned RECIP9 = 3641;
  localparam int          SHIFT9 = 15;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    logic shift;
    logic emit;
    logic last;
    logic row_up;
    logic row_dn;
    logic col_l;
    logic col_r;
  } ctl_t;

  typedef struct packed {
    pixel_t [8:0] px;
    logic         row_up;
    logic         row_dn;
    logic         col_l;
    logic         col_r;
    logic         last;
  } nbh_t;

  typedef struct packed {
    logic [2:0][SUM_W-1:0] sum;
    logic                  rows3;
    logic                  cols3;
    logic                  last;
  } sum_t;

endpackage

`default_nettype wire

@@ rtl/core/bb3_ctrl.sv @@
`default_nettype none

module bb3_ctrl #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  input  wire logic                          cfg_index,
  input  wire logic [bb3_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  input  wire logic                          in_ready,
  input  wire logic                          flush,
  input  wire bb3_pkg::pixel_t               pixel,
  output logic                               load,
  output logic [$clog2(MAX_WIDTH)-1:0]       addr,
  output bb3_pkg::pixel_t                    bottom,
  output bb3_pkg::ctl_t                      ctl
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int CW    = (WID_W > bb3_pkg::FW_W) ? WID_W : bb3_pkg::FW_W;
  localparam int FH_W  = bb3_pkg::FH_W;

  logic [bb3_pkg::FW_W-1:0] frame_width;
  logic [FH_W-1:0]          frame_height;
  logic [COL_W-1:0]         in_col, in_col_next;
  logic [FH_W-1:0]          in_row, in_row_next;
  logic [COL_W-1:0]         out_col, out_col_next;
  logic [FH_W-1:0]          out_row, out_row_next;

  logic [CW-1:0]    fw_x;
  logic [CW-1:0]    w_x;
  logic [WID_W-1:0] w;
  logic [FH_W-1:0]  h;
  logic [COL_W-1:0] c;
  logic [WID_W-1:0] c1;
  logic             take;
  logic             at_first;
  logic             emit;
  logic             last;
  logic             out_end_col;
  logic             restart_now;

  // clamped frame size
  always_comb begin
    fw_x = CW'(frame_width);
    if (fw_x < CW'(bb3_pkg::MIN_SIZE)) begin
      w_x = CW'(bb3_pkg::MIN_SIZE);
    end else if (fw_x > CW'(MAX_WIDTH)) begin
      w_x = CW'(MAX_WIDTH);
    end else begin
      w_x = fw_x;
    end
    w = w_x[WID_W-1:0];
    h = (frame_height < FH_W'(bb3_pkg::MIN_SIZE)) ? FH_W'(bb3_pkg::MIN_SIZE) : frame_height;
  end

  always_comb begin
    take        = (flush == (in_row >= h));
    c           = (WID_W'(in_col) >= w) ? '0 : in_col;
    at_first    = (c == '0);
    emit        = at_first ? (in_row >= FH_W'(2)) : (in_row != '0);
    out_end_col = (WID_W'(out_col) == w - 1'b1);
    last        = (out_row == h - 1'b1) && out_end_col;
    restart_now = at_first && emit && last;
    c1          = WID_W'(c) + 1'b1;

    ctl.shift  = !restart_now;
    ctl.emit   = emit;
    ctl.last   = last;
    ctl.row_up = (out_row != '0);
    ctl.row_dn = (out_row < h - 1'b1);
    ctl.col_l  = (out_col != '0);
    ctl.col_r  = !at_first && !out_end_col;

    load   = in_valid && in_ready && take;
    addr   = c;
    bottom = flush ? '0 : pixel;
  end

  always_comb begin
    in_col_next  = in_col;
    in_row_next  = in_row;
    out_col_next = out_col;
    out_row_next = out_row;
    if (cfg_valid) begin
      in_col_next  = '0;
      in_row_next  = '0;
      out_col_next = '0;
      out_row_next = '0;
    end else if (load) begin
      if (restart_now) begin
        in_col_next  = '0;
        in_row_next  = '0;
        out_col_next = '0;
        out_row_next = '0;
      end else begin
        if (emit) begin
          if (last) begin
            out_col_next = '0;
            out_row_next = '0;
          end else if (out_end_col) begin
            out_col_next = '0;
            out_row_next = out_row + 1'b1;
          end else begin
            out_col_next = out_col + 1'b1;
          end
        end
        if (c1 >= w) begin
          in_col_next = '0;
          if (in_row < h) begin
            in_row_next = in_row + 1'b1;
          end
        end else begin
          in_col_next = c1[COL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bb3_pkg::FRAME_WIDTH_RST;
      frame_height <= bb3_pkg::FRAME_HEIGHT_RST;
      in_col       <= '0;
      in_row       <= '0;
      out_col      <= '0;
      out_row      <= '0;
    end else begin
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
      if (cfg_valid) begin
        case (cfg_index)
          bb3_pkg::REG_FRAME_WIDTH: begin
            frame_width <= cfg_data[bb3_pkg::FW_W-1:0];
          end
          bb3_pkg::REG_FRAME_HEIGHT: begin
            frame_height <= cfg_data[FH_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bb3_window.sv @@
`default_nettype none

module bb3_window #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        load,
  input  wire logic [$clog2(MAX_WIDTH)-1:0] addr,
  input  wire bb3_pkg::pixel_t             bottom,
  input  wire bb3_pkg::ctl_t               ctl,
  output logic                             free,
  output logic                             nb_valid,
  input  wire logic                        nb_ready,
  output bb3_pkg::nbh_t                    nb
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int PIX_W = bb3_pkg::PIX_W;

  // each entry holds the upper row pixel above the middle row pixel
  logic [2*PIX_W-1:0]     line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0]     line_rd;

  logic                   s1_valid;
  bb3_pkg::ctl_t          s1_ctl;
  logic [COL_W-1:0]       s1_addr;
  bb3_pkg::pixel_t        s1_bottom;

  bb3_pkg::pixel_t [8:0]  win;
  bb3_pkg::pixel_t [8:0]  win_next;
  logic                   nb_free;
  logic                   s1_go;

  always_comb begin
    win_next    = win;
    win_next[0] = win[1];
    win_next[1] = win[2];
    win_next[3] = win[4];
    win_next[4] = win[5];
    win_next[6] = win[7];
    win_next[7] = win[8];
    win_next[2] = line_rd[2*PIX_W-1:PIX_W];
    win_next[5] = line_rd[PIX_W-1:0];
    win_next[8] = s1_bottom;
  end

  assign nb_free = !nb_valid || nb_ready;
  assign free    = !s1_valid || !s1_ctl.emit || nb_free;
  assign s1_go   = s1_valid && (!s1_ctl.emit || nb_free);

  always_ff @(posedge clk) begin
    if (s1_go && s1_ctl.shift) begin
      line_mem[s1_addr] <= {line_rd[PIX_W-1:0], s1_bottom};
    end
    if (load) begin
      line_rd <= line_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_ctl    <= ctl;
      s1_addr   <= addr;
      s1_bottom <= bottom;
    end
    if (s1_go && s1_ctl.emit) begin
      nb.px     <= win_next;
      nb.row_up <= s1_ctl.row_up;
      nb.row_dn <= s1_ctl.row_dn;
      nb.col_l  <= s1_ctl.col_l;
      nb.col_r  <= s1_ctl.col_r;
      nb.last   <= s1_ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      nb_valid <= 1'b0;
      win      <= '0;
    end else begin
      if (load) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go && s1_ctl.emit) begin
        nb_valid <= 1'b1;
      end else if (nb_ready) begin
        nb_valid <= 1'b0;
      end
      if (s1_go && s1_ctl.shift) begin
        win <= win_next;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bb3_sum.sv @@
`default_nettype none

module bb3_sum (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          nb_valid,
  output logic               nb_ready,
  input  wire bb3_pkg::nbh_t nb,
  output logic               sum_valid,
  input  wire logic          sum_ready,
  output bb3_pkg::sum_t      sum
);

  localparam int CH_W  = bb3_pkg::CH_W;
  localparam int SUM_W = bb3_pkg::SUM_W;

  logic [2:0]            row_ok;
  logic [2:0]            col_ok;
  logic [2:0][SUM_W-1:0] acc;

  always_comb begin
    row_ok = {nb.row_dn, 1'b1, nb.row_up};
    col_ok = {nb.col_r, 1'b1, nb.col_l};
    acc    = '0;
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 9; k++) begin
        if (row_ok[k / 3] && col_ok[k % 3]) begin
          acc[ch] = acc[ch] + SUM_W'(nb.px[k][ch*CH_W +: CH_W]);
        end
      end
    end
  end

  assign nb_ready = !sum_valid || sum_ready;

  always_ff @(posedge clk) begin
    if (nb_valid && nb_ready) begin
      sum.sum   <= acc;
      sum.rows3 <= nb.row_up && nb.row_dn;
      sum.cols3 <= nb.col_l && nb.col_r;
      sum.last  <= nb.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (nb_ready) begin
      sum_valid <= nb_valid;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bb3_div.sv @@
`default_nettype none

module bb3_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          sum_valid,
  output logic                               sum_ready,
  input  wire bb3_pkg::sum_t                 sum,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [bb3_pkg::PIX_W-1:0]          out_data,
  output logic                               out_last
);

  localparam int CH_W   = bb3_pkg::CH_W;
  localparam int SUM_W  = bb3_pkg::SUM_W;
  localparam int PROD_W = bb3_pkg::PROD_W;

  logic [2:0][SUM_W:0]    x4;
  logic [2:0][SUM_W:0]    x6;
  logic [2:0][SUM_W:0]    x9;
  logic [2:0][PROD_W-1:0] p6;
  logic [2:0][PROD_W-1:0] p9;
  logic [2:0][CH_W-1:0]   mean;

  // round half up: floor((2s+n)/(2n)) for n of 4, 6 and 9
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      x4[ch] = {1'b0, sum.sum[ch]} + (SUM_W+1)'(2);
      x6[ch] = {1'b0, sum.sum[ch]} + (SUM_W+1)'(3);
      x9[ch] = {1'b0, sum.sum[ch]} + (SUM_W+1)'(4);
      p6[ch] = PROD_W'(x6[ch]) * PROD_W'(bb3_pkg::RECIP6);
      p9[ch] = PROD_W'(x9[ch]) * PROD_W'(bb3_pkg::RECIP9);
      if (sum.rows3 && sum.cols3) begin
        mean[ch] = p9[ch][bb3_pkg::SHIFT9 +: CH_W];
      end else if (sum.rows3 || sum.cols3) begin
        mean[ch] = p6[ch][bb3_pkg::SHIFT6 +: CH_W];
      end else begin
        mean[ch] = x4[ch][2 +: CH_W];
      end
    end
  end

  assign sum_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (sum_valid && sum_ready) begin
      out_data <= {mean[2], mean[1], mean[0]};
      out_last <= sum.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sum_ready) begin
      out_valid <= sum_valid;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/box_blur_3x3_rgb.sv @@
// channel   dir  signals                                   content
// s_axis    in   tvalid tready tdata[23:0] tuser           pixel in, tuser = flush tick
// m_axis    out  tvalid tready tdata[23:0] tlast           blurred pixel, tlast = frame end
// cfg       in   valid ready index data[15:0]              0 frame_width, 1 frame_height
//
// one item per clock sustained while m_axis does not stall; the item that completes a neighbourhood
// passes the line store read, window and sum registers into the divide stage's output register
// reset clears counters, window and stage valids; the line stores are not cleared
// a stall on m_axis fills the stages back to front before s_axis_tready drops
// a config write restarts the frame counters
`default_nettype none

module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [23:0]               s_axis_tdata,  // blue_in, green_in, red_in
  input  wire logic                      s_axis_tuser,  // command
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic [23:0]                    m_axis_tdata,  // blue_out, green_out, red_out
  output logic                           m_axis_tlast,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic                      cfg_index,
  input  wire logic [bb3_pkg::CFG_W-1:0] cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic                  load;
  logic [COL_W-1:0]      addr;
  bb3_pkg::pixel_t       bottom;
  bb3_pkg::ctl_t         ctl;
  logic                  nb_valid;
  logic                  nb_ready;
  bb3_pkg::nbh_t         nb;
  logic                  sum_valid;
  logic                  sum_ready;
  bb3_pkg::sum_t         sum;

  assign cfg_ready = 1'b1;

  bb3_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .flush     (s_axis_tuser),
    .pixel     (s_axis_tdata),
    .load      (load),
    .addr      (addr),
    .bottom    (bottom),
    .ctl       (ctl)
  );

  bb3_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .addr     (addr),
    .bottom   (bottom),
    .ctl      (ctl),
    .free     (s_axis_tready),
    .nb_valid (nb_valid),
    .nb_ready (nb_ready),
    .nb       (nb)
  );

  bb3_sum u_sum (
    .clk       (clk),
    .rst       (rst),
    .nb_valid  (nb_valid),
    .nb_ready  (nb_ready),
    .nb        (nb),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum       (sum)
  );

  bb3_div u_div (
    .clk       (clk),
    .rst       (rst),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum       (sum),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

`default_nettype wire

@@ tb/tb_box_blur_3x3_rgb.sv @@
`timescale 1ns / 100ps

module tb_box_blur_3x3_rgb;

  localparam int BLUR_MAX_W    = 1024;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SMALL_ITEMS   = 280;
  localparam int CUT_ITEMS     = 40;

  typedef struct packed {
    logic       frame_last;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } blur_res_t;

  typedef struct packed {
    logic      took;
    logic      hit;
    blur_res_t res;
  } blur_pred_t;

  typedef struct packed {
    logic                      is_cfg;
    logic                      cfg_idx;
    logic [bb3_pkg::CFG_W-1:0] cfg_val;
    logic                      cmd;
    logic [23:0]               data;
    logic                      typed;
    blur_res_t                 want;
  } stim_row_t;

  localparam blur_res_t WHITE_MID = {1'b0, 8'hFF, 8'hFF, 8'hFF};
  localparam blur_res_t WHITE_END = {1'b1, 8'hFF, 8'hFF, 8'hFF};
  localparam blur_res_t BLACK_MID = {1'b0, 8'h00, 8'h00, 8'h00};
  localparam blur_res_t BLACK_END = {1'b1, 8'h00, 8'h00, 8'h00};
  localparam blur_res_t MIX_MID   = {1'b0, 8'd0, 8'd255, 8'd1};
  localparam blur_res_t MIX_END   = {1'b1, 8'd0, 8'd255, 8'd1};

  logic                      clk;
  logic                      rst;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [23:0]               s_axis_tdata;
  logic                      s_axis_tuser;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [23:0]               m_axis_tdata;
  logic                      m_axis_tlast;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic                      cfg_index;
  logic [bb3_pkg::CFG_W-1:0] cfg_data;

  // blur predictor state
  bb3_pkg::pixel_t          older_row [BLUR_MAX_W];
  bb3_pkg::pixel_t          newer_row [BLUR_MAX_W];
  bb3_pkg::pixel_t          blur_win [9];
  int                       next_col;
  int                       next_row;
  int                       next_out;
  logic [bb3_pkg::FW_W-1:0] width_cfg;
  logic [bb3_pkg::FH_W-1:0] height_cfg;

  blur_res_t blur_expected [$];
  blur_res_t oldest_blur;
  stim_row_t dir_rows [$];

  int tx_idle_pct;
  int rx_stall_pct;
  int hold_req;
  int hold_seen;
  int hold_left;
  int cycles;
  int mismatches;
  int items_in;
  int useful;
  int results_seen;
  int cfg_writes;
  int frames_sent;

  box_blur_3x3_rgb #(
    .MAX_WIDTH(BLUR_MAX_W)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit roll(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int used_w();
    int w;
    w = width_cfg;
    if (w < bb3_pkg::MIN_SIZE) w = bb3_pkg::MIN_SIZE;
    if (w > BLUR_MAX_W) w = BLUR_MAX_W;
    return w;
  endfunction

  function automatic int used_h();
    int h;
    h = height_cfg;
    if (h < bb3_pkg::MIN_SIZE) h = bb3_pkg::MIN_SIZE;
    return h;
  endfunction

  function automatic void restart_counts();
    next_col = 0;
    next_row = 0;
    next_out = 0;
  endfunction

  function automatic void blur_model_reset();
    for (int i = 0; i < BLUR_MAX_W; i++) begin
      older_row[i] = '0;
      newer_row[i] = '0;
    end
    for (int i = 0; i < 9; i++) blur_win[i] = '0;
    restart_counts();
    width_cfg  = bb3_pkg::FRAME_WIDTH_RST;
    height_cfg = bb3_pkg::FRAME_HEIGHT_RST;
  endfunction

  function automatic void blur_config(logic idx, logic [bb3_pkg::CFG_W-1:0] val);
    if (idx == bb3_pkg::REG_FRAME_WIDTH) begin
      width_cfg = val[bb3_pkg::FW_W-1:0];
    end else begin
      height_cfg = val[bb3_pkg::FH_W-1:0];
    end
    restart_counts();
  endfunction

  // new column into the window, line stores roll down one row
  function automatic void shift_in(int c, bb3_pkg::pixel_t bottom);
    bb3_pkg::pixel_t top;
    bb3_pkg::pixel_t mid;
    if (c < BLUR_MAX_W) begin
      top = older_row[c];
      mid = newer_row[c];
      for (int k = 0; k < 3; k++) begin
        blur_win[k*3]   = blur_win[k*3+1];
        blur_win[k*3+1] = blur_win[k*3+2];
      end
      blur_win[2] = top;
      blur_win[5] = mid;
      blur_win[8] = bottom;
      older_row[c] = mid;
      newer_row[c] = bottom;
    end
  endfunction

  // rounded mean of the in-frame neighbours, centre at window column wcol
  function automatic blur_res_t blur_mean(int wcol, int w, int h);
    int              cr;
    int              cc;
    int              rr;
    int              col;
    int              wc;
    int              sr;
    int              sg;
    int              sb;
    int              n;
    bb3_pkg::pixel_t px;
    blur_res_t       res;
    cr = next_out / w;
    cc = next_out % w;
    sr = 0;
    sg = 0;
    sb = 0;
    n  = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      rr = cr + dr;
      if (rr >= 0 && rr <= h - 1) begin
        for (int dc = -1; dc <= 1; dc++) begin
          col = cc + dc;
          wc  = wcol + dc;
          if (col >= 0 && col <= w - 1 && wc >= 0 && wc <= 2) begin
            px = blur_win[(dr+1)*3 + wc];
            sr += px[23:16];
            sg += px[15:8];
            sb += px[7:0];
            n++;
          end
        end
      end
    end
    if (n == 0) n = 1;
    res.red        = 8'((2*sr + n) / (2*n));
    res.green      = 8'((2*sg + n) / (2*n));
    res.blue       = 8'((2*sb + n) / (2*n));
    res.frame_last = (next_out == w*h - 1);
    if (res.frame_last) restart_counts();
    else next_out++;
    return res;
  endfunction

  // px holds red in the top byte, blue in the bottom byte
  function automatic blur_pred_t blur_step(logic flush, bb3_pkg::pixel_t px);
    int              w;
    int              h;
    int              c;
    int              r;
    bb3_pkg::pixel_t bottom;
    blur_pred_t      p;
    w = used_w();
    h = used_h();
    p = '0;
    if (flush != (next_row >= h)) return p;
    p.took = 1'b1;
    bottom = flush ? '0 : px;
    c = next_col;
    r = next_row;
    if (c >= w) c = 0;
    if (c == 0) begin
      if (r >= 2) begin
        p.res = blur_mean(2, w, h);
        p.hit = 1'b1;
        if (p.res.frame_last) return p;
      end
      shift_in(c, bottom);
    end else begin
      shift_in(c, bottom);
      if (r >= 1) begin
        p.res = blur_mean(1, w, h);
        p.hit = 1'b1;
      end
    end
    if (c + 1 >= w) begin
      next_col = 0;
      if (r < h) next_row = r + 1;
    end else begin
      next_col = c + 1;
    end
    return p;
  endfunction

  function automatic void dir_px(logic cmd, logic [23:0] data, logic typed, blur_res_t want);
    stim_row_t row_new;
    row_new       = '0;
    row_new.cmd   = cmd;
    row_new.data  = data;
    row_new.typed = typed;
    row_new.want  = want;
    dir_rows.push_back(row_new);
  endfunction

  function automatic void dir_cfg(logic idx, logic [bb3_pkg::CFG_W-1:0] val);
    stim_row_t row_new;
    row_new         = '0;
    row_new.is_cfg  = 1'b1;
    row_new.cfg_idx = idx;
    row_new.cfg_val = val;
    dir_rows.push_back(row_new);
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  function automatic void set_idle(int mode);
    case (mode)
      0: begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end
      1: begin
        tx_idle_pct  = 53;
        rx_stall_pct = 0;
      end
      2: begin
        tx_idle_pct  = 0;
        rx_stall_pct = 53;
      end
      default: begin
        tx_idle_pct  = 19;
        rx_stall_pct = 19;
      end
    endcase
  endfunction

  // entered and left at a falling edge; tvalid stays high for the next item
  task automatic offer_item(input logic cmd, input logic [23:0] data, input logic typed,
                            input blur_res_t want);
    blur_pred_t p;
    while (roll(tx_idle_pct)) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= cmd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    p = blur_step(cmd, {data[7:0], data[15:8], data[23:16]});
    items_in++;
    if (p.took) useful++;
    if (typed) blur_expected.push_back(want);
    else if (p.hit) blur_expected.push_back(p.res);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [bb3_pkg::CFG_W-1:0] val);
    s_axis_tvalid <= 1'b0;
    while (blur_expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    blur_config(idx, val);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // pixels with stray flushes, then the flushes with stray pixels
  task automatic send_frame();
    int w;
    int h;
    w = used_w();
    h = used_h();
    for (int i = 0; i < w*h; i++) begin
      if (roll(4)) offer_item(1'b1, 24'($urandom()), 1'b0, '0);
      offer_item(1'b0, 24'($urandom()), 1'b0, '0);
    end
    for (int i = 0; i <= w; i++) begin
      if (roll(4)) offer_item(1'b0, 24'($urandom()), 1'b0, '0);
      offer_item(1'b1, 24'($urandom()), 1'b0, '0);
    end
    if (roll(15)) offer_item(1'b1, 24'($urandom()), 1'b0, '0);
    frames_sent++;
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (blur_expected.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result: expected none actual tdata %h tlast %b",
                 $time, m_axis_tdata, m_axis_tlast);
      end else begin
        oldest_blur = blur_expected.pop_front();
        check_field("red_out", oldest_blur.red, m_axis_tdata[7:0]);
        check_field("green_out", oldest_blur.green, m_axis_tdata[15:8]);
        check_field("blue_out", oldest_blur.blue, m_axis_tdata[23:16]);
        check_field("frame_last", oldest_blur.frame_last, m_axis_tlast);
      end
    end
  end

  // output side, with the long hold counted here
  initial begin
    m_axis_tready = 1'b0;
    hold_seen     = 0;
    hold_left     = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= !roll(rx_stall_pct);
      end
      @(negedge clk);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("run stopped at the cycle limit, %0d results still awaited",
             blur_expected.size());
    $display("Mismatches found");
    $finish;
  end

  initial begin
    stim_row_t                 row_now;
    int                        phase;
    int                        start_useful;
    logic [bb3_pkg::CFG_W-1:0] v;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = bb3_pkg::REG_FRAME_WIDTH;
    cfg_data      = '0;
    hold_req      = 0;
    mismatches    = 0;
    items_in      = 0;
    useful        = 0;
    results_seen  = 0;
    cfg_writes    = 0;
    frames_sent   = 0;
    set_idle(0);
    blur_model_reset();

    // reset size: no result possible, flush ignored
    dir_px(1'b0, 24'hFFFFFF, 1'b0, '0);
    dir_px(1'b0, 24'h000000, 1'b0, '0);
    dir_px(1'b1, 24'h5A5A5A, 1'b0, '0);
    dir_cfg(bb3_pkg::REG_FRAME_WIDTH, 16'd2);
    dir_cfg(bb3_pkg::REG_FRAME_HEIGHT, 16'd2);
    // white 2x2 frame
    dir_px(1'b0, 24'hFFFFFF, 1'b0, '0);
    dir_px(1'b0, 24'hFFFFFF, 1'b0, '0);
    dir_px(1'b0, 24'hFFFFFF, 1'b0, '0);
    dir_px(1'b0, 24'hFFFFFF, 1'b1, WHITE_MID);
    dir_px(1'b1, 24'hA5C3F0, 1'b1, WHITE_MID);
    dir_px(1'b1, 24'h0F3C5A, 1'b1, WHITE_MID);
    dir_px(1'b1, 24'hFFFFFF, 1'b1, WHITE_END);
    // extra flush after frame end
    dir_px(1'b1, 24'h123456, 1'b0, '0);
    // black frame, pixel dropped while flushes are pending
    dir_px(1'b0, 24'h000000, 1'b0, '0);
    dir_px(1'b0, 24'h000000, 1'b0, '0);
    dir_px(1'b0, 24'h000000, 1'b0, '0);
    dir_px(1'b0, 24'h000000, 1'b1, BLACK_MID);
    dir_px(1'b0, 24'hFFFFFF, 1'b0, '0);
    dir_px(1'b1, 24'hFFFFFF, 1'b1, BLACK_MID);
    dir_px(1'b1, 24'h000000, 1'b1, BLACK_MID);
    dir_px(1'b1, 24'h808080, 1'b1, BLACK_END);
    // half rounds up, just under half rounds down
    dir_px(1'b0, 24'h00FF02, 1'b0, '0);
    dir_px(1'b0, 24'h01FE00, 1'b0, '0);
    dir_px(1'b0, 24'h00FF00, 1'b0, '0);
    dir_px(1'b0, 24'h00FF00, 1'b1, MIX_MID);
    dir_px(1'b1, 24'h000000, 1'b1, MIX_MID);
    dir_px(1'b1, 24'h000000, 1'b1, MIX_MID);
    dir_px(1'b1, 24'h000000, 1'b1, MIX_END);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      row_now = dir_rows[i];
      if (row_now.is_cfg) write_reg(row_now.cfg_idx, row_now.cfg_val);
      else offer_item(row_now.cmd, row_now.data, row_now.typed, row_now.want);
    end

    // widest frame, both sizes clamped, cut short by the next register write
    set_idle(1);
    write_reg(bb3_pkg::REG_FRAME_WIDTH, 16'hFFFF);
    write_reg(bb3_pkg::REG_FRAME_HEIGHT, 16'h0001);
    repeat (CUT_ITEMS) offer_item(1'b0, 24'($urandom()), 1'b0, '0);

    // zero sizes clamp to 2x2
    set_idle(2);
    write_reg(bb3_pkg::REG_FRAME_WIDTH, 16'h0000);
    write_reg(bb3_pkg::REG_FRAME_HEIGHT, 16'h0000);
    send_frame();

    // tallest frame, cut short by the next register write
    set_idle(3);
    write_reg(bb3_pkg::REG_FRAME_WIDTH, 16'hF801);
    write_reg(bb3_pkg::REG_FRAME_HEIGHT, 16'hFFFF);
    repeat (CUT_ITEMS) offer_item(1'b0, 24'($urandom()), 1'b0, '0);

    phase        = 0;
    start_useful = useful;
    while (useful - start_useful < SMALL_ITEMS) begin
      set_idle(phase % 4);
      v        = bb3_pkg::CFG_W'($urandom());
      v[10:0]  = 11'($urandom_range(2, 8));
      if (phase == 0 || used_h() > 8 || $urandom_range(0, 2) != 2)
        write_reg(bb3_pkg::REG_FRAME_WIDTH, v);
      if (phase == 0 || used_h() > 8 || $urandom_range(0, 2) != 1)
        write_reg(bb3_pkg::REG_FRAME_HEIGHT, bb3_pkg::CFG_W'($urandom_range(2, 6)));
      if (phase == 0) hold_req++;
      repeat ($urandom_range(1, 3)) begin
        if (roll(85)) begin
          send_frame();
        end else begin
          repeat ($urandom_range(4, 20))
            offer_item(1'($urandom()), 24'($urandom()), 1'b0, '0);
        end
      end
      phase++;
    end

    s_axis_tvalid <= 1'b0;
    while (blur_expected.size() != 0) @(negedge clk);
    repeat (2 * SETTLE_CYCLES) @(negedge clk);

    $display("sent %0d items (%0d taken by the blur), checked %0d results, %0d frames",
             items_in, useful, results_seen, frames_sent);
    $display("%0d register writes, frames 2x2 to 8x6, clamped wide and tall frames cut short",
             cfg_writes);
    if (mismatches == 0 && blur_expected.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/bb3_pkg.sv
rtl/core/bb3_ctrl.sv
rtl/core/bb3_window.sv
rtl/core/bb3_sum.sv
rtl/core/bb3_div.sv
rtl/core/box_blur_3x3_rgb.sv
tb/tb_box_blur_3x3_rgb.sv
